// ===== sv/ogtc_pkg.sv =====
package ogtc_pkg;

  // Time counter width default (range 32 to 64)
  localparam int TIME_WIDTH_DEF = 48;

  // Event kinds
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_RC      = 3'd1;
  localparam logic [2:0] FUNC_STATUS  = 3'd2;
  localparam logic [2:0] FUNC_CONTROL = 3'd3;
  localparam logic [2:0] FUNC_HBEAT   = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_ON_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_OFF_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESH_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFBOARD_CODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY         = 3'd6;

  // Register reset values
  localparam logic [15:0]        RST_BUTTON_MASK   = 16'd1024;
  localparam logic signed [15:0] RST_AUX_ON_LEVEL  = 16'sd19661;  // 0.6 in Q1.15
  localparam logic signed [15:0] RST_AUX_OFF_LEVEL = 16'sd13107;  // 0.4 in Q1.15
  localparam logic [23:0]        RST_FRESH_TIMEOUT = 24'd500000;
  localparam logic [7:0]         RST_OFFBOARD_CODE = 8'd14;
  localparam logic [23:0]        RST_WARMUP        = 24'd1000000;
  localparam logic [23:0]        RST_RETRY         = 24'd500000;

  typedef struct packed {
    logic [2:0]         func;
    logic [47:0]        now_time;
    logic               rc_ok;
    logic signed [15:0] aux_level;
    logic [15:0]        buttons;
    logic [7:0]         nav_code;
  } ogtc_in_t;

  typedef struct packed {
    logic gate_is_open;
    logic request_armed;
    logic send_mode_command;
    logic forward_control;
    logic send_heartbeat;
  } ogtc_out_t;

endpackage

// ===== sv/offboard_gate_trigger_controller.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data (ogtc_in_t)
// out     | output    | out_valid / out_ready  | out_data (ogtc_out_t)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high; an accepted item passes the input register,
// then the event logic into the result register, which drives out_valid.
// The event path is a TIME_WIDTH-bit subtract and compare on the stored timestamps.
// Reset (rst_n low, synchronous) clears the valid flags and event state and loads register defaults.
// A stalled output holds one result while one more item waits in the input register.
// cfg_ready is always high.
module offboard_gate_trigger_controller #(
  parameter int TIME_WIDTH = ogtc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ogtc_pkg::ogtc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ogtc_pkg::ogtc_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ogtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogtc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ogtc_pkg::*;

  // configuration registers
  logic [15:0]        button_mask_r;
  logic signed [15:0] aux_on_r;
  logic signed [15:0] aux_off_r;
  logic [23:0]        fresh_timeout_r;
  logic [7:0]         offb_code_r;
  logic [23:0]        warmup_r;
  logic [23:0]        retry_r;

  // pipeline registers
  logic      in_vld_r;
  ogtc_in_t  in_r;
  logic      out_vld_r;
  ogtc_out_t out_r;
  logic      adv;

  // event state
  logic                  rc_valid_r;
  logic signed [15:0]    aux_r;
  logic [15:0]           buttons_r;
  logic                  prev_btn_r, prev_btn_nxt;
  logic                  prev_aux_r, prev_aux_nxt;
  logic                  status_seen_r;
  logic [7:0]            nav_r;
  logic                  ctl_seen_r;
  logic [TIME_WIDTH-1:0] last_ctl_r;
  logic                  req_r, req_nxt;
  logic [TIME_WIDTH-1:0] req_start_r;
  logic                  cmd_sent_r, cmd_sent_nxt;
  logic [TIME_WIDTH-1:0] last_cmd_r;
  logic                  gate_r, gate_nxt;

  // tick datapath
  logic [TIME_WIDTH-1:0] now_w;
  logic [TIME_WIDTH-1:0] age_ctl, age_req, age_cmd;
  logic btn_on, aux_on, edge_hit, fresh, offb, send, tick;
  ogtc_out_t res;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_mask_r   <= RST_BUTTON_MASK;
      aux_on_r        <= RST_AUX_ON_LEVEL;
      aux_off_r       <= RST_AUX_OFF_LEVEL;
      fresh_timeout_r <= RST_FRESH_TIMEOUT;
      offb_code_r     <= RST_OFFBOARD_CODE;
      warmup_r        <= RST_WARMUP;
      retry_r         <= RST_RETRY;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BUTTON_MASK:   button_mask_r   <= cfg_data[15:0];
        CFG_AUX_ON_LEVEL:  aux_on_r        <= $signed(cfg_data[15:0]);
        CFG_AUX_OFF_LEVEL: aux_off_r       <= $signed(cfg_data[15:0]);
        CFG_FRESH_TIMEOUT: fresh_timeout_r <= cfg_data;
        CFG_OFFBOARD_CODE: offb_code_r     <= cfg_data[7:0];
        CFG_WARMUP:        warmup_r        <= cfg_data;
        CFG_RETRY:         retry_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: input register drains into the result register
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // age of stored timestamps, modulo the time width
  assign now_w   = TIME_WIDTH'(in_r.now_time);
  assign age_ctl = now_w - last_ctl_r;
  assign age_req = edge_hit ? '0 : now_w - req_start_r;
  assign age_cmd = now_w - last_cmd_r;

  // trigger sources: masked buttons and aux hysteresis (on test first)
  always_comb begin
    btn_on = (buttons_r & button_mask_r) == button_mask_r;
    if (aux_r > aux_on_r) begin
      aux_on = 1'b1;
    end else if (aux_r < aux_off_r) begin
      aux_on = 1'b0;
    end else begin
      aux_on = prev_aux_r;
    end
  end

  // tick decision
  always_comb begin
    tick         = in_r.func == FUNC_TICK;
    edge_hit     = rc_valid_r && ((btn_on && !prev_btn_r) || (aux_on && !prev_aux_r));
    prev_btn_nxt = rc_valid_r && btn_on;
    prev_aux_nxt = rc_valid_r && aux_on;
    fresh        = ctl_seen_r && (age_ctl < TIME_WIDTH'(fresh_timeout_r));
    offb         = status_seen_r && (nav_r == offb_code_r);
    req_nxt      = edge_hit || (req_r && rc_valid_r && fresh);
    cmd_sent_nxt = cmd_sent_r && !edge_hit;
    send         = req_nxt && fresh && !offb &&
                   (age_req >= TIME_WIDTH'(warmup_r)) &&
                   (!cmd_sent_nxt || (age_cmd >= TIME_WIDTH'(retry_r)));
    gate_nxt     = req_nxt && fresh && offb;
  end

  // result of this item
  always_comb begin
    res = '0;
    res.gate_is_open  = gate_r;
    res.request_armed = req_r;
    case (in_r.func)
      FUNC_TICK: begin
        res.gate_is_open      = gate_nxt;
        res.request_armed     = req_nxt;
        res.send_mode_command = send;
      end
      FUNC_CONTROL: res.forward_control = gate_r;
      FUNC_HBEAT:   res.send_heartbeat  = req_r;
      default: ;
    endcase
  end

  // state update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_valid_r    <= 1'b0;
      aux_r         <= '0;
      buttons_r     <= '0;
      prev_btn_r    <= 1'b0;
      prev_aux_r    <= 1'b0;
      status_seen_r <= 1'b0;
      nav_r         <= '0;
      ctl_seen_r    <= 1'b0;
      last_ctl_r    <= '0;
      req_r         <= 1'b0;
      req_start_r   <= '0;
      cmd_sent_r    <= 1'b0;
      last_cmd_r    <= '0;
      gate_r        <= 1'b0;
    end else if (adv) begin
      case (in_r.func)
        FUNC_TICK: begin
          prev_btn_r <= prev_btn_nxt;
          prev_aux_r <= prev_aux_nxt;
          req_r      <= req_nxt;
          gate_r     <= gate_nxt;
          cmd_sent_r <= cmd_sent_nxt || send;
          if (edge_hit) begin
            req_start_r <= now_w;
          end
          if (send) begin
            last_cmd_r <= now_w;
          end
        end
        FUNC_RC: begin
          rc_valid_r <= in_r.rc_ok;
          aux_r      <= in_r.aux_level;
          buttons_r  <= in_r.buttons;
        end
        FUNC_STATUS: begin
          nav_r         <= in_r.nav_code;
          status_seen_r <= 1'b1;
        end
        FUNC_CONTROL: begin
          ctl_seen_r <= 1'b1;
          last_ctl_r <= now_w;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  // gate never open without an armed request
  a_gate_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    gate_r |-> req_r)
    else $error("gate open without request");

  // mode command only on a tick, never while the gate is open
  a_cmd_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && send && tick) |=> (out_r.request_armed && !out_r.gate_is_open))
    else $error("mode command with gate open or no request");

  // a result reports at most one action
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot0({out_r.send_mode_command, out_r.forward_control,
                            out_r.send_heartbeat}))
    else $error("more than one action in a result");

  // a waiting item is never dropped while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("pending item lost");

  // result register only loads from a pending item
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r && !in_vld_r) |=> !out_vld_r)
    else $error("result without an item");

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ogtc_pkg::*;

  // event kinds the block does not know; they must leave all state alone
  localparam logic [2:0] FUNC_UNDEF_FIRST = FUNC_HBEAT + 3'd1;
  localparam logic [2:0] FUNC_UNDEF_LAST  = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD    = 300;

  typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_e;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ogtc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ogtc_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  offboard_gate_trigger_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // settings copy for the gate model
  logic [15:0]        m_mask      = RST_BUTTON_MASK;
  logic signed [15:0] m_aux_on    = RST_AUX_ON_LEVEL;
  logic signed [15:0] m_aux_off   = RST_AUX_OFF_LEVEL;
  logic [23:0]        m_fresh     = RST_FRESH_TIMEOUT;
  logic [7:0]         m_offb_code = RST_OFFBOARD_CODE;
  logic [23:0]        m_warmup    = RST_WARMUP;
  logic [23:0]        m_retry     = RST_RETRY;

  // gate model state
  logic               m_rc_valid    = 1'b0;
  logic signed [15:0] m_aux         = '0;
  logic [15:0]        m_buttons     = '0;
  logic               m_prev_btn    = 1'b0;
  logic               m_prev_aux    = 1'b0;
  logic               m_status_seen = 1'b0;
  logic [7:0]         m_nav         = '0;
  logic               m_ctrl_seen   = 1'b0;
  logic [47:0]        m_last_ctrl   = '0;
  logic               m_request     = 1'b0;
  logic [47:0]        m_req_time    = '0;
  logic               m_cmd_sent    = 1'b0;
  logic [47:0]        m_last_cmd    = '0;
  logic               m_gate        = 1'b0;

  ogtc_in_t    pending_events[$];
  ogtc_out_t   expected_gate_outputs[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned accepted_items = 0;
  int unsigned cycle_count = 0;

  // Advance the gate model by one event and return the result it produces
  function automatic ogtc_out_t gate_outcome(ogtc_in_t ev);
    ogtc_out_t   r;
    logic        trig, btn_held, aux_act, fresh, offb, fire_cmd;
    logic [47:0] ctrl_age, req_age, cmd_age;
    r = '0;
    case (ev.func)
      FUNC_TICK: begin
        trig = 1'b0;
        if (!m_rc_valid) begin
          m_prev_btn = 1'b0;
          m_prev_aux = 1'b0;
        end else begin
          btn_held = (m_buttons & m_mask) == m_mask;
          trig = btn_held && !m_prev_btn;
          m_prev_btn = btn_held;
          // on test wins when the levels overlap
          if (m_aux > m_aux_on) aux_act = 1'b1;
          else if (m_aux < m_aux_off) aux_act = 1'b0;
          else aux_act = m_prev_aux;
          trig = trig || (aux_act && !m_prev_aux);
          m_prev_aux = aux_act;
        end
        ctrl_age = ev.now_time - m_last_ctrl;
        fresh = m_ctrl_seen && (ctrl_age < 48'(m_fresh));
        offb = m_status_seen && (m_nav == m_offb_code);
        if (!m_rc_valid || !fresh) m_request = 1'b0;
        if (trig) begin
          m_request = 1'b1;
          m_req_time = ev.now_time;
          m_cmd_sent = 1'b0;
        end
        req_age = ev.now_time - m_req_time;
        cmd_age = ev.now_time - m_last_cmd;
        fire_cmd = m_request && fresh && !offb && (req_age >= 48'(m_warmup)) &&
                   (!m_cmd_sent || cmd_age >= 48'(m_retry));
        if (fire_cmd) begin
          m_last_cmd = ev.now_time;
          m_cmd_sent = 1'b1;
        end
        m_gate = m_request && fresh && offb;
        r.send_mode_command = fire_cmd;
      end
      FUNC_RC: begin
        m_rc_valid = ev.rc_ok;
        m_aux = ev.aux_level;
        m_buttons = ev.buttons;
      end
      FUNC_STATUS: begin
        m_nav = ev.nav_code;
        m_status_seen = 1'b1;
      end
      FUNC_CONTROL: begin
        m_ctrl_seen = 1'b1;
        m_last_ctrl = ev.now_time;
        r.forward_control = m_gate;
      end
      FUNC_HBEAT: r.send_heartbeat = m_request;
      default: ;
    endcase
    r.gate_is_open = m_gate;
    r.request_armed = m_request;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR t=%0t result %0d: %s got %0d expected %0d", $realtime, results_seen,
             what, got, want);
    mismatches++;
  endtask

  task automatic add_event(input logic [2:0] f, input logic [47:0] t, input logic ok,
                           input logic signed [15:0] aux, input logic [15:0] btn,
                           input logic [7:0] nav);
    ogtc_in_t ev;
    ev.func = f;
    ev.now_time = t;
    ev.rc_ok = ok;
    ev.aux_level = aux;
    ev.buttons = btn;
    ev.nav_code = nav;
    pending_events.push_back(ev);
  endtask

  // Register write; the model copy changes when the write is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUTTON_MASK:   m_mask = val[15:0];
      CFG_AUX_ON_LEVEL:  m_aux_on = val[15:0];
      CFG_AUX_OFF_LEVEL: m_aux_off = val[15:0];
      CFG_FRESH_TIMEOUT: m_fresh = val;
      CFG_OFFBOARD_CODE: m_offb_code = val[7:0];
      CFG_WARMUP:        m_warmup = val;
      CFG_RETRY:         m_retry = val;
      default: ;
    endcase
  endtask

  // Unused upper data bits get random values; the block must ignore them
  task automatic program_settings(input logic [15:0] mask, input logic [15:0] on_lvl,
                                  input logic [15:0] off_lvl, input logic [23:0] fresh,
                                  input logic [7:0] code, input logic [23:0] warm,
                                  input logic [23:0] retry);
    write_reg(CFG_BUTTON_MASK, {8'($urandom), mask});
    write_reg(CFG_AUX_ON_LEVEL, {8'($urandom), on_lvl});
    write_reg(CFG_AUX_OFF_LEVEL, {8'($urandom), off_lvl});
    write_reg(CFG_FRESH_TIMEOUT, fresh);
    write_reg(CFG_OFFBOARD_CODE, {16'($urandom), code});
    write_reg(CFG_WARMUP, warm);
    write_reg(CFG_RETRY, retry);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is in and every result is out; missing ones are flagged
  task automatic wait_drained();
    int unsigned waited;
    while (pending_events.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_gate_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_gate_outputs.size() != 0) begin
      report_mismatch("results never delivered", expected_gate_outputs.size(), 0);
      expected_gate_outputs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random event stream; time steps scale with the freshness window
  task automatic queue_random_events(input int unsigned count);
    int unsigned        step, real_items, pick;
    logic [47:0]        t;
    logic [2:0]         kind;
    logic [15:0]        btn;
    logic signed [15:0] aux;
    logic [7:0]         nav;
    step = m_fresh / 3 + 1;
    t = {16'($urandom), 32'($urandom)};
    real_items = 0;
    while (real_items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) t -= $urandom_range(1, step * 4);
      else if (pick < 7) t += step * 8 + $urandom_range(0, step);
      else t += $urandom_range(0, step);

      pick = $urandom_range(0, 99);
      if (pick < 35) kind = FUNC_TICK;
      else if (pick < 50) kind = FUNC_RC;
      else if (pick < 60) kind = FUNC_STATUS;
      else if (pick < 85) kind = FUNC_CONTROL;
      else if (pick < 95) kind = FUNC_HBEAT;
      else kind = 3'($urandom_range(FUNC_UNDEF_FIRST, FUNC_UNDEF_LAST));

      case ($urandom_range(0, 2))
        0: btn = m_mask | 16'($urandom);
        1: btn = 16'($urandom) & ~m_mask;
        default: btn = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: aux = 16'($urandom);
        1: aux = m_aux_on + 16'sd1;
        2: aux = m_aux_off - 16'sd1;
        3: aux = m_aux_on;
        default: aux = m_aux_off;
      endcase
      nav = $urandom_range(0, 1) ? m_offb_code : 8'($urandom);

      add_event(kind, t, $urandom_range(0, 9) != 0, aux, btn, nav);
      if (kind <= FUNC_HBEAT) real_items++;
    end
  endtask

  // Sender: bursts from the pending queue with random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_gate_outputs.push_back(gate_outcome(in_data));
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_events.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: randomly chosen stall patterns, plus one long hold-off
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && accepted_items >= 60) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (cycle_count % 50 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_HALF:    out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
        default:    out_ready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    ogtc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_gate_outputs.size() == 0) begin
        report_mismatch("result with no expectation", out_data, 0);
      end else begin
        want = expected_gate_outputs.pop_front();
        if (out_data.gate_is_open !== want.gate_is_open)
          report_mismatch("gate_is_open", out_data.gate_is_open, want.gate_is_open);
        if (out_data.request_armed !== want.request_armed)
          report_mismatch("request_armed", out_data.request_armed, want.request_armed);
        if (out_data.send_mode_command !== want.send_mode_command)
          report_mismatch("send_mode_command", out_data.send_mode_command,
                          want.send_mode_command);
        if (out_data.forward_control !== want.forward_control)
          report_mismatch("forward_control", out_data.forward_control,
                          want.forward_control);
        if (out_data.send_heartbeat !== want.send_heartbeat)
          report_mismatch("send_heartbeat", out_data.send_heartbeat, want.send_heartbeat);
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    logic [47:0] t0;
    t0 = 48'h0000_1000_0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset settings
    add_event(FUNC_UNDEF_FIRST, t0, 1'b1, 16'sh7FFF, 16'hFFFF, 8'hFF);
    add_event(FUNC_TICK, t0 + 48'd10, 1'b0, '0, '0, '0);       // no rc, no control yet
    add_event(FUNC_CONTROL, t0 + 48'd20, 1'b0, '0, '0, '0);
    add_event(FUNC_HBEAT, t0 + 48'd30, 1'b0, '0, '0, '0);
    add_event(FUNC_RC, t0 + 48'd40, 1'b1, -16'sd32768, 16'hFFFF, '0);
    add_event(FUNC_TICK, t0 + 48'd50, 1'b0, '0, '0, '0);       // button trigger arms
    add_event(FUNC_HBEAT, t0 + 48'd60, 1'b0, '0, '0, '0);
    add_event(FUNC_CONTROL, t0 + 48'd900000, 1'b0, '0, '0, '0);
    add_event(FUNC_TICK, t0 + 48'd1000100, 1'b0, '0, '0, '0);  // first command after warm-up
    add_event(FUNC_TICK, t0 + 48'd1200000, 1'b0, '0, '0, '0);  // inside retry interval
    add_event(FUNC_CONTROL, t0 + 48'd1300000, 1'b0, '0, '0, '0);
    add_event(FUNC_TICK, t0 + 48'd1600100, 1'b0, '0, '0, '0);  // retried command
    add_event(FUNC_STATUS, t0 + 48'd1650000, 1'b0, '0, '0, RST_OFFBOARD_CODE);
    add_event(FUNC_TICK, t0 + 48'd1700000, 1'b0, '0, '0, '0);  // gate opens
    add_event(FUNC_CONTROL, t0 + 48'd1750000, 1'b0, '0, '0, '0);
    add_event(FUNC_RC, t0 + 48'd1760000, 1'b1, 16'sh7FFF, 16'h0000, '0);
    add_event(FUNC_TICK, t0 + 48'd1770000, 1'b0, '0, '0, '0);  // aux trigger re-arms
    add_event(FUNC_STATUS, t0 + 48'd1780000, 1'b0, '0, '0, 8'hFF);
    add_event(FUNC_RC, t0 + 48'd1790000, 1'b0, '0, RST_BUTTON_MASK, '0);
    add_event(FUNC_TICK, t0 + 48'd1800000, 1'b0, '0, '0, '0);  // invalid rc drops request
    add_event(FUNC_CONTROL, 48'hFFFF_FFFF_FFF0, 1'b0, '0, '0, '0);
    add_event(FUNC_RC, 48'hFFFF_FFFF_FFFF, 1'b1, 16'sh4000, RST_BUTTON_MASK, '0);
    add_event(FUNC_TICK, 48'h0000_0000_0005, 1'b0, '0, '0, '0); // wrapped time, still fresh
    add_event(FUNC_CONTROL, 48'h0000_0000_0010, 1'b0, '0, '0, '0);
    add_event(FUNC_TICK, 48'h0000_0000_0008, 1'b0, '0, '0, '0); // time went backwards
    add_event(FUNC_UNDEF_LAST, 48'h0000_0000_0020, 1'b0, -16'sd1, 16'h5A5A, 8'h0F);
    wait_drained();

    // short windows so that arming, commands and gating all happen often
    program_settings(16'h0003, 16'sd8192, -16'sd8192, 24'd6000, 8'd14, 24'd3000, 24'd1500);
    queue_random_events(110);
    wait_drained();

    // upper extremes: aux never switches, no warm-up or retry wait holds back a command
    program_settings(16'hFFFF, 16'sh7FFF, 16'sh8000, 24'hFFFFFF, 8'hFF, 24'd0, 24'd0);
    queue_random_events(70);
    wait_drained();

    // lower extremes: control is never fresh, on level below off level
    program_settings(16'h0000, 16'sh8000, 16'sh7FFF, 24'd0, 8'd0, 24'hFFFFFF, 24'hFFFFFF);
    queue_random_events(30);
    wait_drained();

    program_settings(16'($urandom & $urandom), 16'($urandom), 16'($urandom),
                     24'($urandom_range(1000, 200000)), 8'($urandom),
                     24'($urandom_range(0, 400000)), 24'($urandom_range(0, 200000)));
    queue_random_events(120);
    wait_drained();

    // overlapping hysteresis with a usable freshness window
    program_settings(16'h8001, -16'sd1000, 16'sd1000, 24'd4000, 8'd200, 24'd0, 24'd700);
    queue_random_events(70);
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
